[rtl/iidl_pkg.sv]
// Shared types, constants and tree-sizing functions for the indexed insert/delete list.
package iidl_pkg;

	// Default sizes of the list.
	localparam int IIDL_CAPACITY  = 64;
	localparam int IIDL_ITEM_BITS = 64;
	localparam int POS_BITS       = 16;

	// Operation codes carried in the request.
	typedef enum logic [2:0] {
		OP_PUSH   = 3'd0,
		OP_INSERT = 3'd1,
		OP_DELETE = 3'd2,
		OP_SET    = 3'd3,
		OP_GET    = 3'd4,
		OP_POP    = 3'd5,
		OP_SHIFT  = 3'd6,
		OP_CLEAR  = 3'd7
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_NEG   = 2'd3
	} status_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic                shift_up;
		logic                shift_down;
		logic                write;
		logic                read;
		logic [POS_BITS-1:0] idx;
	} cell_cmd_t;

	// Number of nodes at a level of the radix-8 read tree (level 0 is the leaves).
	function automatic int tree_size(int leaves, int lvl);
		int n;
		n = leaves;
		for (int k = 0; k < lvl; k++) begin
			n = (n + 7) >> 3;
		end
		return n;
	endfunction

	// Number of registered levels above the leaves.
	function automatic int tree_levels(int leaves);
		int n;
		int lv;
		n  = leaves;
		lv = 0;
		while (n > 1) begin
			n  = (n + 7) >> 3;
			lv = lv + 1;
		end
		if (lv == 0) begin
			lv = 1;
		end
		return lv;
	endfunction

	// Offset of a level's first node in the flat node array (levels from 1).
	function automatic int tree_base(int leaves, int lvl);
		int b;
		b = 0;
		for (int m = 1; m < lvl; m++) begin
			b = b + tree_size(leaves, m);
		end
		return b;
	endfunction

endpackage

[rtl/iidl_if.sv]
// Request and response channel interfaces of the indexed insert/delete list.
interface iidl_req_if
	import iidl_pkg::*;
#(
	parameter int ITEM_BITS = IIDL_ITEM_BITS
);
	logic                       valid;
	logic                       ready;
	logic [2:0]                 opcode;
	logic signed [POS_BITS-1:0] position;
	logic [ITEM_BITS-1:0]       item_in;

	modport source (output valid, opcode, position, item_in, input ready);
	modport sink (input valid, opcode, position, item_in, output ready);
endinterface

interface iidl_rsp_if
	import iidl_pkg::*;
#(
	parameter int ITEM_BITS = IIDL_ITEM_BITS,
	parameter int CNT_BITS  = $clog2(IIDL_CAPACITY + 1)
);
	logic                 valid;
	logic                 ready;
	logic [ITEM_BITS-1:0] item_out;
	logic [CNT_BITS-1:0]  count_after;
	logic [1:0]           status;

	modport source (output valid, item_out, count_after, status, input ready);
	modport sink (input valid, item_out, count_after, status, output ready);
endinterface

[rtl/indexed_insert_delete_list.sv]
// Top level of the indexed insert/delete list: decode, cell row, read tree and result buffer.
//
//   Channel  Direction  Payload                          Handshake
//   req      in         opcode, position, item_in        valid / ready
//   rsp      out        item_out, count_after, status    valid / ready
//
// Each request updates the cell row at the edge where it is accepted; every cell shifts,
// loads or holds in that same cycle, so insert and delete finish their row work there.
// The result leaves after the cell taps and the registered read tree, and a new request is
// taken once the previous one leaves the tree and the second buffer entry is free.
// A result buffer of two entries lets a request enter while a finished result waits.
// Reset clears the count and all control state; entry storage keeps whatever it holds.
module indexed_insert_delete_list
	import iidl_pkg::*;
#(
	parameter int CAPACITY  = IIDL_CAPACITY,
	parameter int ITEM_BITS = IIDL_ITEM_BITS
) (
	input logic        clk,
	input logic        arst_n,
	iidl_req_if.sink   req,
	iidl_rsp_if.source rsp
);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int NLEV   = tree_levels(CAPACITY);
	localparam int WAIT_W = $clog2(NLEV + 1);

	logic [CNT_W-1:0]     count_q;
	logic                 inflight_q;
	logic [WAIT_W-1:0]    wait_q;
	logic                 out_valid_q;
	logic                 skid_valid_q;
	logic [CNT_W-1:0]     meta_cnt_q;
	status_t              meta_st_q;
	logic [ITEM_BITS-1:0] out_item_q;
	logic [CNT_W-1:0]     out_cnt_q;
	status_t              out_st_q;
	logic [ITEM_BITS-1:0] skid_item_q;
	logic [CNT_W-1:0]     skid_cnt_q;
	status_t              skid_st_q;

	logic                 accept;
	logic                 done;
	logic                 take;
	cell_cmd_t            cmd;
	logic [CNT_W-1:0]     next_cnt;
	status_t              next_st;
	logic [POS_BITS-1:0]  cnt_wide;
	logic [POS_BITS-1:0]  pos_mag;
	logic                 neg;
	logic                 in_rng;
	logic                 full;
	logic                 empty;
	logic [ITEM_BITS-1:0] cell_val [CAPACITY];
	logic [ITEM_BITS-1:0] cell_tap [CAPACITY];
	logic [ITEM_BITS-1:0] root;

	assign accept = req.valid && req.ready;
	assign take   = out_valid_q && rsp.ready;
	assign done   = inflight_q && (wait_q == '0);

	assign req.ready = !inflight_q && !skid_valid_q;

	// Range checks of the request against the current count.
	assign cnt_wide = POS_BITS'(count_q);
	assign neg      = req.position[POS_BITS-1];
	assign pos_mag  = {1'b0, req.position[POS_BITS-2:0]};
	assign in_rng   = !neg && (pos_mag < cnt_wide);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);

	// Operation decode into the cell command, the new count and the status.
	always_comb begin
		cmd      = '0;
		next_cnt = count_q;
		next_st  = ST_OK;
		unique case (op_t'(req.opcode))
			OP_PUSH: begin
				if (full) begin
					next_st = ST_FULL;
				end else begin
					cmd.write = 1'b1;
					cmd.idx   = cnt_wide;
					next_cnt  = count_q + 1'b1;
				end
			end
			OP_INSERT: begin
				if (neg) begin
					next_st = ST_NEG;
				end else if (full) begin
					next_st = ST_FULL;
				end else begin
					cmd.shift_up = 1'b1;
					cmd.idx      = (pos_mag > cnt_wide) ? cnt_wide : pos_mag;
					next_cnt     = count_q + 1'b1;
				end
			end
			OP_DELETE: begin
				if (!in_rng) begin
					next_st = ST_RANGE;
				end else begin
					cmd.shift_down = 1'b1;
					cmd.read       = 1'b1;
					cmd.idx        = pos_mag;
					next_cnt       = count_q - 1'b1;
				end
			end
			OP_SET: begin
				if (!in_rng) begin
					next_st = ST_RANGE;
				end else begin
					cmd.write = 1'b1;
					cmd.read  = 1'b1;
					cmd.idx   = pos_mag;
				end
			end
			OP_GET: begin
				if (!in_rng) begin
					next_st = ST_RANGE;
				end else begin
					cmd.read = 1'b1;
					cmd.idx  = pos_mag;
				end
			end
			OP_POP: begin
				if (empty) begin
					next_st = ST_RANGE;
				end else begin
					cmd.read = 1'b1;
					cmd.idx  = cnt_wide - 1'b1;
					next_cnt = count_q - 1'b1;
				end
			end
			OP_SHIFT: begin
				if (empty) begin
					next_st = ST_RANGE;
				end else begin
					cmd.shift_down = 1'b1;
					cmd.read       = 1'b1;
					cmd.idx        = '0;
					next_cnt       = count_q - 1'b1;
				end
			end
			OP_CLEAR: begin
				next_cnt = '0;
			end
			default: begin
				next_cnt = count_q;
			end
		endcase
	end

	// The row of cells; each sees its two neighbors and the broadcast command.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ITEM_BITS-1:0] left_val;
		logic [ITEM_BITS-1:0] right_val;

		if (i == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_mid_l
			assign left_val = cell_val[i - 1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_mid_r
			assign right_val = cell_val[i + 1];
		end

		iidl_cell #(
			.ITEM_BITS (ITEM_BITS),
			.IDX       (i)
		) u_cell (
			.clk       (clk),
			.en        (accept),
			.cmd       (cmd),
			.item      (req.item_in),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (cell_val[i]),
			.tap       (cell_tap[i])
		);
	end

	// Read tree that brings the selected old entry out of the row.
	iidl_or_tree #(
		.ITEM_BITS (ITEM_BITS),
		.LEAVES    (CAPACITY)
	) u_tree (
		.clk  (clk),
		.taps (cell_tap),
		.root (root)
	);

	// Count, in-flight tracking and the two-entry result buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			inflight_q   <= 1'b0;
			wait_q       <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= next_cnt;
				inflight_q <= 1'b1;
				wait_q     <= WAIT_W'(NLEV);
			end else if (done) begin
				inflight_q <= 1'b0;
			end else if (inflight_q) begin
				wait_q <= wait_q - 1'b1;
			end

			if (take) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= done;
				end else begin
					out_valid_q <= done;
				end
			end else if (done) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	// Payload side of the result path.
	always_ff @(posedge clk) begin
		if (accept) begin
			meta_cnt_q <= next_cnt;
			meta_st_q  <= next_st;
		end
		if (take && skid_valid_q) begin
			out_item_q <= skid_item_q;
			out_cnt_q  <= skid_cnt_q;
			out_st_q   <= skid_st_q;
		end else if (done && (!out_valid_q || take)) begin
			out_item_q <= root;
			out_cnt_q  <= meta_cnt_q;
			out_st_q   <= meta_st_q;
		end
		if (done && (skid_valid_q || (out_valid_q && !take))) begin
			skid_item_q <= root;
			skid_cnt_q  <= meta_cnt_q;
			skid_st_q   <= meta_st_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.item_out    = out_item_q;
	assign rsp.count_after = out_cnt_q;
	assign rsp.status      = out_st_q;
endmodule

[rtl/iidl_cell.sv]
// One storage cell of the list row: holds one entry and trades it with its neighbors.
module iidl_cell
	import iidl_pkg::*;
#(
	parameter int ITEM_BITS = IIDL_ITEM_BITS,
	parameter int IDX       = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  cell_cmd_t            cmd,
	input  logic [ITEM_BITS-1:0] item,
	input  logic [ITEM_BITS-1:0] left_val,
	input  logic [ITEM_BITS-1:0] right_val,
	output logic [ITEM_BITS-1:0] val,
	output logic [ITEM_BITS-1:0] tap
);
	localparam logic [POS_BITS-1:0] MY_IDX = POS_BITS'(IDX);

	logic [ITEM_BITS-1:0] val_q;
	logic [ITEM_BITS-1:0] tap_q;

	// The read tap captures the old entry; the entry then moves, is written or holds.
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q <= (cmd.read && cmd.idx == MY_IDX) ? val_q : '0;
			if (cmd.shift_up) begin
				if (MY_IDX > cmd.idx) begin
					val_q <= left_val;
				end else if (MY_IDX == cmd.idx) begin
					val_q <= item;
				end
			end else if (cmd.shift_down) begin
				if (MY_IDX >= cmd.idx) begin
					val_q <= right_val;
				end
			end else if (cmd.write && cmd.idx == MY_IDX) begin
				val_q <= item;
			end
		end
	end

	assign val = val_q;
	assign tap = tap_q;
endmodule

[rtl/iidl_or_tree.sv]
// Registered radix-8 OR tree that gathers the one selected cell tap into a single word.
module iidl_or_tree
	import iidl_pkg::*;
#(
	parameter int ITEM_BITS = IIDL_ITEM_BITS,
	parameter int LEAVES    = IIDL_CAPACITY
) (
	input  logic                 clk,
	input  logic [ITEM_BITS-1:0] taps [LEAVES],
	output logic [ITEM_BITS-1:0] root
);
	localparam int NLEV  = tree_levels(LEAVES);
	localparam int TOTAL = tree_base(LEAVES, NLEV + 1);
	localparam int ROOT  = tree_base(LEAVES, NLEV);

	logic [ITEM_BITS-1:0] node [TOTAL];

	// Each node ORs up to eight children of the level below and registers the result.
	for (genvar k = 1; k <= NLEV; k++) begin : g_lvl
		localparam int NK = tree_size(LEAVES, k);
		localparam int NP = tree_size(LEAVES, k - 1);
		localparam int BK = tree_base(LEAVES, k);
		localparam int BP = (k > 1) ? tree_base(LEAVES, k - 1) : 0;
		for (genvar j = 0; j < NK; j++) begin : g_node
			localparam int NC = (NP - 8 * j < 8) ? (NP - 8 * j) : 8;
			logic [ITEM_BITS-1:0] sum;
			logic [ITEM_BITS-1:0] sum_q;

			// The first level reads the cell taps; higher levels read the nodes below.
			if (k == 1) begin : g_leaf
				always_comb begin
					sum = '0;
					for (int c = 0; c < NC; c++) begin
						sum = sum | taps[8 * j + c];
					end
				end
			end else begin : g_inner
				always_comb begin
					sum = '0;
					for (int c = 0; c < NC; c++) begin
						sum = sum | node[BP + 8 * j + c];
					end
				end
			end

			always_ff @(posedge clk) begin
				sum_q <= sum;
			end

			assign node[BK + j] = sum_q;
		end
	end

	assign root = node[ROOT];
endmodule

[rtl/iidl_checker.sv]
// Port-level checker for the indexed insert/delete list and its bind to the top level.
module iidl_checker
	import iidl_pkg::*;
#(
	parameter int CAPACITY  = IIDL_CAPACITY,
	parameter int ITEM_BITS = IIDL_ITEM_BITS
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [ITEM_BITS-1:0]          item_out,
	input logic [$clog2(CAPACITY+1)-1:0] count_after,
	input logic [1:0]                    status
);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// The count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (count_after <= CNT_W'(CAPACITY)))
		else $error("count_after exceeds capacity");

	// A refused push or insert reports a full list.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_FULL) |-> (count_after == CNT_W'(CAPACITY)))
		else $error("full status with count below capacity");

	// A failed request returns no entry.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ST_OK) |-> (item_out == '0))
		else $error("nonzero item on failed request");

	// A stalled result holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(item_out)
			&& $stable(count_after) && $stable(status)))
		else $error("stalled result changed");
endmodule

bind indexed_insert_delete_list iidl_checker #(
	.CAPACITY  (CAPACITY),
	.ITEM_BITS (ITEM_BITS)
) u_iidl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.item_out    (rsp.item_out),
	.count_after (rsp.count_after),
	.status      (rsp.status)
);

[test/tb_indexed_insert_delete_list.sv]
// Self-checking testbench for the indexed insert/delete list: random list operations checked against a behavioral list.
module tb_indexed_insert_delete_list;
	import iidl_pkg::*;

	localparam int CNT_BITS    = $clog2(IIDL_CAPACITY + 1);
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 360;

	// One expected response, with the operation kept for reporting.
	typedef struct {
		op_t                 op;
		logic [63:0]         item;
		logic [CNT_BITS-1:0] count;
		status_t             st;
	} list_result_t;

	// Behavioral copy of the list and the queue of responses it predicts.
	class list_scoreboard;
		logic [63:0]  slots [IIDL_CAPACITY];
		int           fill;
		list_result_t expected_q [$];
		int           mismatches;

		function new();
			fill       = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Apply an accepted request to the list and queue the response it should produce.
		function void note_request(op_t op, logic signed [POS_BITS-1:0] pos, logic [63:0] value);
			list_result_t exp;
			int           p;
			int           at;
			p        = pos;
			exp.op   = op;
			exp.item = '0;
			exp.st   = ST_OK;
			case (op)
				OP_PUSH: begin
					if (fill >= IIDL_CAPACITY) begin
						exp.st = ST_FULL;
					end else begin
						slots[fill] = value;
						fill++;
					end
				end
				OP_INSERT: begin
					if (p < 0) begin
						exp.st = ST_NEG;
					end else if (fill >= IIDL_CAPACITY) begin
						exp.st = ST_FULL;
					end else begin
						// An index past the end becomes an append.
						at = (p > fill) ? fill : p;
						for (int i = fill; i > at; i--) begin
							slots[i] = slots[i-1];
						end
						slots[at] = value;
						fill++;
					end
				end
				OP_DELETE: begin
					if (p < 0 || p >= fill) begin
						exp.st = ST_RANGE;
					end else begin
						exp.item = slots[p];
						for (int i = p; i + 1 < fill; i++) begin
							slots[i] = slots[i+1];
						end
						fill--;
					end
				end
				OP_SET: begin
					if (p < 0 || p >= fill) begin
						exp.st = ST_RANGE;
					end else begin
						exp.item = slots[p];
						slots[p] = value;
					end
				end
				OP_GET: begin
					if (p < 0 || p >= fill) begin
						exp.st = ST_RANGE;
					end else begin
						exp.item = slots[p];
					end
				end
				OP_POP: begin
					if (fill == 0) begin
						exp.st = ST_RANGE;
					end else begin
						fill--;
						exp.item = slots[fill];
					end
				end
				OP_SHIFT: begin
					if (fill == 0) begin
						exp.st = ST_RANGE;
					end else begin
						exp.item = slots[0];
						for (int i = 1; i < fill; i++) begin
							slots[i-1] = slots[i];
						end
						fill--;
					end
				end
				default: begin
					// Clear only drops the count; stored values stay.
					fill = 0;
				end
			endcase
			exp.count = CNT_BITS'(fill);
			expected_q.push_back(exp);
		endfunction

		// Compare one accepted response with the oldest prediction.
		function void check_result(logic [63:0] item, logic [CNT_BITS-1:0] count, logic [1:0] st);
			list_result_t exp;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected response: item %h count %0d status %0d", item, count, st);
				end
				return;
			end
			exp = expected_q.pop_front();
			if (item !== exp.item || count !== exp.count || st !== exp.st) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch on %s: expected item %h count %0d status %s, got item %h count %0d status %0d",
						exp.op.name(), exp.item, exp.count, exp.st.name(), item, count, st);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   send_idle_pct;
	int   rsp_stall_pct;

	list_scoreboard sb = new();

	iidl_req_if #(.ITEM_BITS(IIDL_ITEM_BITS)) req_ch ();
	iidl_rsp_if #(.ITEM_BITS(IIDL_ITEM_BITS)) rsp_ch ();

	indexed_insert_delete_list #(
		.CAPACITY  (IIDL_CAPACITY),
		.ITEM_BITS (IIDL_ITEM_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = ~clk;
	end

	// Cycle counter with a hard limit on the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Response side: random back-pressure, driven at the falling edge.
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// Check every accepted response at the rising edge.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			sb.check_result(rsp_ch.item_out, rsp_ch.count_after, rsp_ch.status);
		end
	end

	function automatic logic [63:0] rand_item();
		return {$urandom, $urandom};
	endfunction

	// Index choice: mostly live entries, some at the end, some far out or negative.
	function automatic logic signed [POS_BITS-1:0] pick_position();
		int r;
		r = $urandom_range(99);
		if (r < 50) begin
			return POS_BITS'($urandom_range(0, (sb.fill > 0) ? sb.fill - 1 : 0));
		end else if (r < 65) begin
			return POS_BITS'(sb.fill + $urandom_range(0, 2));
		end else if (r < 80) begin
			return POS_BITS'($urandom);
		end else if (r < 90) begin
			return -POS_BITS'($urandom_range(1, 4));
		end else if (r < 94) begin
			return 16'sh7FFF;
		end else if (r < 97) begin
			return 16'sh8000;
		end else begin
			return POS_BITS'($urandom_range(0, 80));
		end
	endfunction

	// Present one request, with random idle cycles first, and record it once accepted.
	task automatic send_request(op_t op, logic signed [POS_BITS-1:0] pos, logic [63:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.opcode   <= op;
		req_ch.position <= pos;
		req_ch.item_in  <= value;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		sb.note_request(op, pos, value);
		@(negedge clk);
	endtask

	// Hold off new requests until every predicted response has arrived.
	task automatic drain_requests();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
	endtask

	// One random request; the mode leans the mix toward growing, shrinking or neither.
	task automatic random_request(int mode);
		op_t op;
		int  r;
		int  add_pct;
		int  rem_pct;
		add_pct = (mode == 0) ? 60 : (mode == 1) ? 15 : 35;
		rem_pct = (mode == 0) ? 15 : (mode == 1) ? 60 : 35;
		r = $urandom_range(99);
		if (r < 1) begin
			op = OP_CLEAR;
		end else if (r < 1 + add_pct) begin
			op = $urandom_range(1) ? OP_PUSH : OP_INSERT;
		end else if (r < 1 + add_pct + rem_pct) begin
			case ($urandom_range(2))
				0: op = OP_DELETE;
				1: op = OP_POP;
				default: op = OP_SHIFT;
			endcase
		end else begin
			op = $urandom_range(1) ? OP_GET : OP_SET;
		end
		send_request(op, pick_position(), rand_item());
	endtask

	// One idling phase: fill to capacity, hit the full cases, then mixed traffic.
	task automatic run_phase(int idle_pct, int stall_pct);
		int done;
		int mode;
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		done = 0;
		while (sb.fill < IIDL_CAPACITY) begin
			if ($urandom_range(1)) begin
				send_request(OP_PUSH, pick_position(), rand_item());
			end else begin
				send_request(OP_INSERT, POS_BITS'($urandom_range(0, sb.fill + 2)), rand_item());
			end
			done++;
		end
		send_request(OP_PUSH, pick_position(), rand_item());
		send_request(OP_INSERT, POS_BITS'($urandom_range(0, IIDL_CAPACITY)), rand_item());
		send_request(OP_INSERT, -POS_BITS'($urandom_range(1, 32768)), rand_item());
		done += 3;
		while (done < PHASE_ITEMS) begin
			mode = $urandom_range(2);
			for (int k = 0; k < 40 && done < PHASE_ITEMS; k++) begin
				random_request(mode);
				done++;
			end
		end
		drain_requests();
	endtask

	// Main sequence: reset, directed cases, four idling phases, then the verdict.
	initial begin
		arst_n          = 1'b0;
		cycle_count     = 0;
		send_idle_pct   = 0;
		rsp_stall_pct   = 0;
		req_ch.valid    = 1'b0;
		req_ch.opcode   = OP_PUSH;
		req_ch.position = '0;
		req_ch.item_in  = '0;
		rsp_ch.ready    = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty list: every read or removal is out of range.
		send_request(OP_POP, 16'sd0, 64'd0);
		send_request(OP_SHIFT, 16'sd0, 64'd0);
		send_request(OP_GET, 16'sd0, 64'd0);
		send_request(OP_DELETE, 16'sd0, 64'd0);
		send_request(OP_SET, 16'sd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(OP_INSERT, 16'sh8000, rand_item());
		send_request(OP_INSERT, -16'sd1, rand_item());
		// Build a short list, including an insert far past the end.
		send_request(OP_PUSH, 16'sd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(OP_PUSH, 16'sd0, 64'd0);
		send_request(OP_INSERT, 16'sh7FFF, rand_item());
		send_request(OP_INSERT, 16'sd0, rand_item());
		send_request(OP_INSERT, 16'sd2, rand_item());
		send_request(OP_GET, 16'sh7FFF, rand_item());
		send_request(OP_GET, 16'sh8000, rand_item());
		send_request(OP_GET, 16'sd5, rand_item());
		send_request(OP_SET, 16'sd2, rand_item());
		send_request(OP_DELETE, 16'sd1, rand_item());
		send_request(OP_DELETE, -16'sd2, rand_item());
		send_request(OP_GET, 16'sd0, rand_item());
		send_request(OP_SHIFT, 16'sd0, rand_item());
		send_request(OP_POP, 16'sd0, rand_item());
		send_request(OP_CLEAR, 16'sd0, rand_item());
		send_request(OP_GET, 16'sd0, rand_item());
		send_request(OP_PUSH, 16'sd0, rand_item());
		send_request(OP_POP, 16'sd0, rand_item());
		drain_requests();

		run_phase(0, 0);
		run_phase(58, 0);
		run_phase(0, 58);
		run_phase(28, 28);

		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
